[rtl/assert_macros.svh]
// Assertion macros used by the checker file nroot_chk.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/nroot_pkg.sv]
// Shared types and constants for the n-th root block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package nroot_pkg;
  localparam int FRAC_BITS = 16;
  localparam int QW = 31;
  localparam logic [QW-1:0] QMAX = {QW{1'b1}};
  localparam logic [QW-1:0] QONE = QW'(1) << FRAC_BITS;

  localparam logic [1:0] ST_CONV  = 2'd0;
  localparam logic [1:0] ST_LIMIT = 2'd1;
  localparam logic [1:0] ST_INVAL = 2'd2;

  localparam logic CFG_TOL = 1'b0;
  localparam logic CFG_LIM = 1'b1;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE  = 4'd0,
    OP_LOAD  = 4'd1,  // latch x, n; start divide x/n
    OP_SETR  = 4'd2,  // r <- quotient; p <- 1.0, k <- 1
    OP_MUL   = 4'd3,  // start p*r
    OP_MULWB = 4'd4,  // p <- product (saturated), k++
    OP_DIVX  = 4'd5,  // start divide x<<F / pm1
    OP_SUM   = 4'd6,  // s <- (n-1)*r + q, start s/n
    OP_UPD   = 4'd7,  // r <- quotient, iters++, p <- 1.0
    OP_SAVEP = 4'd8   // pm1 <- p
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mul_done;
    logic k_lt_n;     // k < n: more multiplies for r^(n-1)
    logic within_tol;
    logic at_limit;
  } dp_sts_t;
endpackage
`default_nettype wire

[rtl/nroot_div.sv]
// Restoring divider, one quotient bit a cycle, saturating 31-bit quotient.
// Depends on nroot_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nroot_div (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [47:0]              dividend,
  input  wire logic [31:0]              divisor,
  output logic                          done,
  output logic [nroot_pkg::QW-1:0]      quot
);
  import nroot_pkg::*;
  logic [47:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] d_r;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_nxt;
  logic [32:0] trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r[31:0], q_r[47]} - {1'b0, d_r};
    if (start) begin
      q_nxt = dividend; rem_nxt = '0; cnt_nxt = 6'd47; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial; q_nxt = {q_r[46:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], q_r[47]}; q_nxt = {q_r[46:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
      cnt_nxt = cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done <= done_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; cnt_r <= cnt_nxt;
    if (start) d_r <= divisor;
  end

  always_comb begin
    if (d_r == '0 || q_r[47:QW] != '0) quot = QMAX;
    else quot = q_r[QW-1:0];
  end
endmodule
`default_nettype wire

[rtl/nroot_dp.sv]
// Datapath: operand registers, one registered multiplier, shared divider.
// Depends on nroot_pkg and nroot_div.
`timescale 1ns / 1ps
`default_nettype none
module nroot_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  nroot_pkg::dp_cmd_t       cmd,
  input  wire logic [31:0]         radicand,
  input  wire logic [3:0]          degree,
  input  wire logic [15:0]         tol,
  input  wire logic [7:0]          lim,
  output nroot_pkg::dp_sts_t       sts,
  output logic [nroot_pkg::QW-1:0] root,
  output logic [7:0]               iters
);
  import nroot_pkg::*;
  logic [QW-1:0] x_r, r_r, p_r, pm1_r;
  logic [3:0]    n_r, k_r;
  logic [7:0]    it_r;
  logic [61:0]   prod_r;
  logic          mdone_r;
  logic          dstart;
  logic [47:0]   dvd;
  logic [31:0]   dvs;
  logic          ddone;
  logic [QW-1:0] dq;
  logic [45:0]   psh;
  logic [QW-1:0] psat, diff;
  logic [35:0]   sum;

  nroot_div u_div (.clk, .rst_n, .start(dstart), .dividend(dvd), .divisor(dvs),
                   .done(ddone), .quot(dq));

  assign psh  = prod_r[61:FRAC_BITS];
  assign psat = (psh[45:QW] != '0) ? QMAX : psh[QW-1:0];
  assign diff = (psat >= x_r) ? psat - x_r : x_r - psat;
  // (n-1)*r + q, up to 14*(2^31-1) + (2^31-1)
  assign sum  = 36'(n_r - 4'd1) * 36'(r_r) + 36'(dq);

  always_comb begin
    dstart = 1'b0; dvd = '0; dvs = '0;
    case (cmd.op)
      OP_LOAD: begin
        dstart = 1'b1; dvd = 48'(radicand[QW-1:0]); dvs = 32'(degree);
      end
      OP_DIVX: begin
        dstart = 1'b1; dvd = 48'(x_r) << FRAC_BITS; dvs = 32'(pm1_r);
      end
      OP_SUM: begin
        dstart = 1'b1; dvd = 48'(sum); dvs = 32'(n_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) mdone_r <= 1'b0;
    else        mdone_r <= (cmd.op == OP_MUL);
    prod_r <= 62'(p_r) * 62'(r_r);
    case (cmd.op)
      OP_LOAD: begin
        x_r <= radicand[QW-1:0]; n_r <= degree; it_r <= '0;
      end
      OP_SETR: begin
        r_r <= dq; p_r <= QONE; k_r <= 4'd1;
      end
      OP_MULWB: begin
        p_r <= psat; k_r <= k_r + 4'd1;
      end
      OP_SAVEP: pm1_r <= p_r;
      OP_UPD: begin
        r_r <= dq; it_r <= it_r + 8'd1; p_r <= QONE; k_r <= 4'd1;
      end
      default: ;
    endcase
  end

  // p holds r^(n-1) once k reaches n; the compare uses the product r^n
  assign sts.div_done   = ddone;
  assign sts.mul_done   = mdone_r;
  assign sts.k_lt_n     = (k_r < n_r);
  assign sts.within_tol = (diff <= QW'(tol));
  assign sts.at_limit   = (it_r >= lim);
  assign root  = r_r;
  assign iters = it_r;
endmodule
`default_nettype wire

[rtl/nroot_ctrl.sv]
// Controller: sequences load, power build, test, divide and update.
// Depends on nroot_pkg.
`timescale 1ns / 1ps
`default_nettype none
module nroot_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_fire,
  input  wire logic          invalid,
  input  wire logic          out_free,
  input  nroot_pkg::dp_sts_t sts,
  output nroot_pkg::dp_cmd_t cmd,
  output logic               busy,
  output logic               res_load,
  output logic [1:0]         res_status,
  output logic               res_inval
);
  import nroot_pkg::*;
  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_DIV0  = 8'b00000010,
    S_POW   = 8'b00000100,
    S_MULW  = 8'b00001000,
    S_TEST  = 8'b00010000,
    S_DIVX  = 8'b00100000,
    S_DIVN  = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;
  state_t st_r, st_nxt;
  logic [1:0] stat_r, stat_nxt;
  logic       last_r, last_nxt;  // product in flight is r^n

  always_comb begin
    st_nxt = st_r; stat_nxt = stat_r; last_nxt = last_r;
    cmd.op = OP_NONE; res_load = 1'b0; res_inval = 1'b0;
    unique case (st_r)
      S_IDLE: if (in_fire) begin
        if (invalid) begin
          res_load = 1'b1; res_inval = 1'b1;
        end else begin
          cmd.op = OP_LOAD; st_nxt = S_DIV0;
        end
      end
      S_DIV0: if (sts.div_done) begin
        cmd.op = OP_SETR; st_nxt = S_POW;
      end
      S_POW: begin
        if (!sts.k_lt_n) begin
          cmd.op = OP_SAVEP; last_nxt = 1'b1;
        end else last_nxt = 1'b0;
        st_nxt = S_MULW;
      end
      S_MULW: begin
        cmd.op = OP_MUL;
        st_nxt = S_TEST;
      end
      S_TEST: if (sts.mul_done) begin
        if (!last_r) begin
          cmd.op = OP_MULWB; st_nxt = S_POW;
        end else if (sts.within_tol) begin
          stat_nxt = ST_CONV; st_nxt = S_DONE;
        end else if (sts.at_limit) begin
          stat_nxt = ST_LIMIT; st_nxt = S_DONE;
        end else begin
          cmd.op = OP_DIVX; st_nxt = S_DIVX;
        end
      end
      S_DIVX: if (sts.div_done) begin
        cmd.op = OP_SUM; st_nxt = S_DIVN;
      end
      S_DIVN: if (sts.div_done) begin
        cmd.op = OP_UPD; st_nxt = S_POW;
      end
      S_DONE: if (out_free) begin
        res_load = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; stat_r <= ST_CONV; last_r <= 1'b0;
    end else begin
      st_r <= st_nxt; stat_r <= stat_nxt; last_r <= last_nxt;
    end
  end

  assign busy       = (st_r != S_IDLE);
  assign res_status = stat_r;
endmodule
`default_nettype wire

[rtl/newton_nth_root.sv]
// Top level of the Newton n-th root block: ports, config registers, output word.
// Depends on nroot_pkg, nroot_ctrl, nroot_dp.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
//  - in_ channel: one word per root request, radicand (signed Q16.16) and degree.
//  - out_ channel: one word per request: root, status, iterations_used.
//  - cfg_ channel: index 0 tolerance, 1 iteration limit; write only while idle.
// Timing: an invalid word (radicand <= 0 or degree 0) is answered next cycle.
//  Otherwise a start divide, then per round degree multiplies (one multiplier
//  reused) plus two divides (x/r^(n-1), then the sum by n) on one shared
//  divider, up to iteration_limit+1 rounds. One word is worked on at a time.
// Reset: clears control and restores tolerance 1, limit 64.
// Stall: the result sits in the output register; a finished word waits in
//  the controller until that register is free. in_tready is low while busy
//  and while the output register holds a word that is not being taken.
module newton_nth_root (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [31:0] radicand, [35:32] degree, zero pad
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [30:0] root, [32:31] status, [40:33] iterations_used
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);
  import nroot_pkg::*;
  logic [15:0] tol_r;
  logic [7:0]  lim_r;
  logic        in_fire, invalid, busy, out_free;
  logic        res_load, res_inval;
  logic [1:0]  res_status;
  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [QW-1:0] root;
  logic [7:0]  iters;
  logic        ov_r;
  logic [47:0] od_r;

  assign in_tready = !busy && out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign invalid   = in_tdata[31] || (in_tdata[31:0] == '0) || (in_tdata[35:32] == '0);
  assign out_free  = !ov_r || out_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= 16'd1; lim_r <= 8'd64;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_TOL: tol_r <= cfg_data;
        CFG_LIM: lim_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  nroot_ctrl u_ctrl (.clk, .rst_n, .in_fire, .invalid, .out_free, .sts, .cmd,
                     .busy, .res_load, .res_status, .res_inval);

  nroot_dp u_dp (.clk, .rst_n, .cmd, .radicand(in_tdata[31:0]),
                 .degree(in_tdata[35:32]), .tol(tol_r), .lim(lim_r), .sts,
                 .root, .iters);

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (res_load) ov_r <= 1'b1;
    else if (out_tready) ov_r <= 1'b0;
    if (res_load) begin
      if (res_inval) od_r <= {7'd0, 8'd0, ST_INVAL, 31'd0};
      else           od_r <= {7'd0, iters, res_status, root};
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
endmodule
`default_nettype wire

[rtl/nroot_chk.sv]
// Port-level checker for newton_nth_root, bound to the top level.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module nroot_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [47:0] out_tdata
);
  `CHK_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "output word dropped while stalled")
  `CHK_IMPL(a_stat, clk, rst_n, out_tvalid, out_tdata[32:31] != 2'd3, "bad status code")
  `CHK_IMPL(a_inv, clk, rst_n, out_tvalid && out_tdata[32:31] == 2'd2, out_tdata[40:0] == 41'h100000000, "invalid word not cleared")
  `CHK_NEXT(a_busy, clk, rst_n, in_tvalid && in_tready, out_tvalid || !in_tready, "second word taken before the first was answered")
endmodule

bind newton_nth_root nroot_chk u_chk (.clk, .rst_n, .in_tvalid, .in_tready,
                                      .out_tvalid, .out_tready, .out_tdata);
`default_nettype wire
